/* hw/rtl/fpr_pkg.sv */
// ----------------------------------------------------------------------------
// fpr_pkg: shared types and constants for the FIFO page replacement core
// Holds field widths, default sizes, sequencer states and the store control
// group used between the controller and the frame store.
// ----------------------------------------------------------------------------
package fpr_pkg;

	localparam int MAX_FRAMES_DEF = 16;
	localparam int PAGE_BITS_DEF  = 16;

	localparam int CFG_W   = 5;
	localparam int PAGE_W  = 16;
	localparam int SLOT_W  = 4;
	localparam int CNT_W   = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EVICT
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} store_ctl_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + CNT_W'(1);
	endfunction

endpackage

/* hw/rtl/fpr_frame_store.sv */
// ----------------------------------------------------------------------------
// fpr_frame_store: resident page memory with per-frame valid bits
// One write and one registered read per cycle. Valid bits clear on reset and
// are set by every write; the read returns the valid bit with the page.
// ----------------------------------------------------------------------------
module fpr_frame_store
	import fpr_pkg::*;
#(
	parameter int DEPTH = MAX_FRAMES_DEF,
	parameter int AW    = 4,
	parameter int DW    = PAGE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  store_ctl_t    ctl,
	input  logic [AW-1:0] rd_addr,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	output logic [DW-1:0] rd_data,
	output logic          rd_valid
);

	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [DW-1:0]    rd_data_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule

/* hw/rtl/fpr_ctrl.sv */
// ----------------------------------------------------------------------------
// fpr_ctrl: lookup sequencer with shared page comparator
// Walks the active frames one read per cycle, compares each returned page,
// then fills the next empty frame or replaces the oldest one on a fault.
// ----------------------------------------------------------------------------
module fpr_ctrl
	import fpr_pkg::*;
#(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF,
	parameter int AW         = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [PAGE_W-1:0]    page_number,
	input  logic [CFG_W-1:0]     frames_in_use,
	output logic                 busy,
	output store_ctl_t           st_ctl,
	output logic [AW-1:0]        st_rd_addr,
	output logic [AW-1:0]        st_wr_addr,
	output logic [PAGE_BITS-1:0] st_wr_data,
	input  logic [PAGE_BITS-1:0] st_rd_data,
	input  logic                 st_rd_valid,
	output logic                 fire,
	output logic                 res_hit,
	output logic [SLOT_W-1:0]    res_slot,
	output logic                 res_evicted_valid,
	output logic [PAGE_W-1:0]    res_evicted_page,
	output logic [CNT_W-1:0]     res_fault_count,
	output logic [CNT_W-1:0]     res_reference_count
);

	localparam int CW = $clog2(MAX_FRAMES + 1);

	state_t               state_q, state_d;
	logic [PAGE_BITS-1:0] page_q;
	logic [CW-1:0]        n_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        filled_q;
	logic [AW-1:0]        oldest_q;
	logic [AW-1:0]        slot_q;
	logic                 pend_s1;
	logic [AW-1:0]        cidx_s1;
	logic [CNT_W-1:0]     faults_q;
	logic [CNT_W-1:0]     refs_q;

	logic [CNT_W-1:0] cfg_wide;
	logic [CW-1:0]    act_n;
	logic             match;
	logic             scan_end;
	logic             table_full;
	logic [AW-1:0]    old_slot;
	logic [AW-1:0]    oldest_next;
	logic             scan_issue;
	logic             do_fill;
	logic             do_evict_rd;
	logic             fault;
	logic [AW-1:0]    slot;

	// A frame count of zero acts as one; anything above the store size is clipped.
	always_comb begin
		cfg_wide = CNT_W'(frames_in_use);
		if (cfg_wide == '0) begin
			act_n = CW'(1);
		end else if (cfg_wide > CNT_W'(MAX_FRAMES)) begin
			act_n = CW'(MAX_FRAMES);
		end else begin
			act_n = CW'(frames_in_use);
		end
	end

	assign match      = pend_s1 && st_rd_valid && (st_rd_data == page_q);
	assign scan_end   = (idx_q == n_q);
	assign table_full = (filled_q >= n_q);
	assign old_slot   = (CW'(oldest_q) < n_q) ? oldest_q : '0;
	assign oldest_next = ((CW'(old_slot) + CW'(1)) < n_q) ? old_slot + AW'(1) : '0;

	always_comb begin
		state_d           = state_q;
		st_ctl            = '0;
		st_rd_addr        = idx_q[AW-1:0];
		st_wr_addr        = slot_q;
		scan_issue        = 1'b0;
		do_fill           = 1'b0;
		do_evict_rd       = 1'b0;
		fault             = 1'b0;
		fire              = 1'b0;
		res_hit           = 1'b0;
		res_evicted_valid = 1'b0;
		res_evicted_page  = '0;
		slot              = cidx_s1;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (match) begin
					fire    = 1'b1;
					res_hit = 1'b1;
					state_d = ST_IDLE;
				end else if (scan_end) begin
					if (!table_full) begin
						do_fill       = 1'b1;
						fault         = 1'b1;
						fire          = 1'b1;
						slot          = filled_q[AW-1:0];
						st_ctl.wr_en  = 1'b1;
						st_wr_addr    = filled_q[AW-1:0];
						state_d       = ST_IDLE;
					end else begin
						// Fetch the victim so its page can be reported next cycle.
						do_evict_rd  = 1'b1;
						st_ctl.rd_en = 1'b1;
						st_rd_addr   = old_slot;
						state_d      = ST_EVICT;
					end
				end else begin
					scan_issue   = 1'b1;
					st_ctl.rd_en = 1'b1;
				end
			end
			ST_EVICT: begin
				fault             = 1'b1;
				fire              = 1'b1;
				slot              = slot_q;
				st_ctl.wr_en      = 1'b1;
				res_evicted_valid = st_rd_valid;
				res_evicted_page  = st_rd_valid ? PAGE_W'(st_rd_data) : '0;
				state_d           = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			n_q      <= CW'(1);
			idx_q    <= '0;
			filled_q <= '0;
			oldest_q <= '0;
			pend_s1  <= 1'b0;
			faults_q <= '0;
			refs_q   <= '0;
		end else begin
			state_q <= state_d;
			pend_s1 <= scan_issue;
			if (state_q == ST_IDLE && start) begin
				n_q   <= act_n;
				idx_q <= '0;
			end else if (scan_issue) begin
				idx_q <= idx_q + CW'(1);
			end
			if (do_fill) begin
				filled_q <= filled_q + CW'(1);
			end
			if (do_evict_rd) begin
				oldest_q <= oldest_next;
			end
			if (fire) begin
				refs_q <= sat_inc(refs_q);
			end
			if (fault) begin
				faults_q <= sat_inc(faults_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			page_q <= PAGE_BITS'(page_number);
		end
		cidx_s1 <= idx_q[AW-1:0];
		if (do_evict_rd) begin
			slot_q <= old_slot;
		end
	end

	assign busy                = (state_q != ST_IDLE);
	assign st_wr_data          = page_q;
	assign res_slot            = SLOT_W'(slot);
	assign res_fault_count     = fault ? sat_inc(faults_q) : faults_q;
	assign res_reference_count = sat_inc(refs_q);

endmodule

/* hw/rtl/fifo_page_replacement_core.sv */
// ----------------------------------------------------------------------------
// fifo_page_replacement_core: FIFO page replacement engine
// Looks up one page reference per item among the active frames, fills or
// replaces a frame on a fault, and reports the result with running counts.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake           Payload
//   -------   ------------------  ------------------------------------------
//   input     start, busy         page_number
//   result    done (strobe)       hit, frame_slot, evicted_valid,
//                                 evicted_page, fault_count, reference_count
//   config    cfg_we              cfg_wdata (frames in use)
//
// A hit ends the walk at the matching frame; a fault walks all active
// frames, then fills the next empty frame or, once the table is full,
// replaces the oldest. The store's single read port paces the walk at one
// frame per cycle. busy is high from the cycle after start until done rises.
// Reset clears the valid bits, pointers, counters and sets four frames.
// done lasts one cycle and cannot be held off.
//
module fifo_page_replacement_core
	import fpr_pkg::*;
#(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF,
	parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [PAGE_W-1:0] page_number,
	input  logic              cfg_we,
	input  logic [CFG_W-1:0]  cfg_wdata,
	output logic              done,
	output logic              hit,
	output logic [SLOT_W-1:0] frame_slot,
	output logic              evicted_valid,
	output logic [PAGE_W-1:0] evicted_page,
	output logic [CNT_W-1:0]  fault_count,
	output logic [CNT_W-1:0]  reference_count
);

	localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

	logic [CFG_W-1:0]     frames_q;
	store_ctl_t           st_ctl;
	logic [AW-1:0]        st_rd_addr;
	logic [AW-1:0]        st_wr_addr;
	logic [PAGE_BITS-1:0] st_wr_data;
	logic [PAGE_BITS-1:0] st_rd_data;
	logic                 st_rd_valid;
	logic                 fire;
	logic                 res_hit;
	logic [SLOT_W-1:0]    res_slot;
	logic                 res_evicted_valid;
	logic [PAGE_W-1:0]    res_evicted_page;
	logic [CNT_W-1:0]     res_fault_count;
	logic [CNT_W-1:0]     res_reference_count;

	logic                 done_q;
	logic                 hit_q;
	logic [SLOT_W-1:0]    slot_q;
	logic                 ev_valid_q;
	logic [PAGE_W-1:0]    ev_page_q;
	logic [CNT_W-1:0]     faults_q;
	logic [CNT_W-1:0]     refs_q;

	fpr_frame_store #(
		.DEPTH (MAX_FRAMES),
		.AW    (AW),
		.DW    (PAGE_BITS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (st_ctl),
		.rd_addr  (st_rd_addr),
		.wr_addr  (st_wr_addr),
		.wr_data  (st_wr_data),
		.rd_data  (st_rd_data),
		.rd_valid (st_rd_valid)
	);

	fpr_ctrl #(
		.MAX_FRAMES (MAX_FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.AW         (AW)
	) u_ctrl (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.page_number         (page_number),
		.frames_in_use       (frames_q),
		.busy                (busy),
		.st_ctl              (st_ctl),
		.st_rd_addr          (st_rd_addr),
		.st_wr_addr          (st_wr_addr),
		.st_wr_data          (st_wr_data),
		.st_rd_data          (st_rd_data),
		.st_rd_valid         (st_rd_valid),
		.fire                (fire),
		.res_hit             (res_hit),
		.res_slot            (res_slot),
		.res_evicted_valid   (res_evicted_valid),
		.res_evicted_page    (res_evicted_page),
		.res_fault_count     (res_fault_count),
		.res_reference_count (res_reference_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= CFG_RESET;
			done_q   <= 1'b0;
		end else begin
			done_q <= fire;
			if (cfg_we) begin
				frames_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hit_q      <= res_hit;
			slot_q     <= res_slot;
			ev_valid_q <= res_evicted_valid;
			ev_page_q  <= res_evicted_page;
			faults_q   <= res_fault_count;
			refs_q     <= res_reference_count;
		end
	end

	assign done            = done_q;
	assign hit             = hit_q;
	assign frame_slot      = slot_q;
	assign evicted_valid   = ev_valid_q;
	assign evicted_page    = ev_page_q;
	assign fault_count     = faults_q;
	assign reference_count = refs_q;

endmodule
